// ----- rtl/bthp_pkg.sv -----
// Shared types and constants of the bootstrap tape header parser.
// Used by the summary interface and by every module of the block; depends on nothing.
package bthp_pkg;

	localparam int POSITION_BITS = 32;
	localparam int MAX_DIGITS    = 50;
	localparam int DIGIT_BITS    = 6;
	localparam int SEEN_BITS     = 3;
	localparam int OFFSET_BITS   = 32;
	localparam int PBYTES_BITS   = 17;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [DIGIT_BITS-1:0] DIGIT_LIMIT = DIGIT_BITS'(MAX_DIGITS);

	localparam logic [6:0] CHAR_BANG  = 7'h21;
	localparam logic [6:0] CHAR_SLASH = 7'h2F;
	localparam logic [6:0] CHAR_CR    = 7'h0D;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_EIGHT = 7'h38;
	localparam logic [6:0] CHAR_NINE  = 7'h39;

	localparam logic [SEEN_BITS-1:0] SEEN_ADDR_CNT = 3'd4;
	localparam logic [SEEN_BITS-1:0] SEEN_CHECKSUM = 3'd6;
	localparam logic [SEEN_BITS-1:0] SEEN_VCOUNT   = 3'd7;
	localparam int MIN_FILE_BYTES = 8;
	localparam int HEADER_SLOTS   = 6;

	localparam logic PHASE_PREAMBLE = 1'b0;
	localparam logic PHASE_HEADER   = 1'b1;

	typedef struct packed {
		logic                     phase;
		logic [15:0]              acc;
		logic [DIGIT_BITS-1:0]    digit_count;
		logic                     stopped;
		logic [15:0]              start;
		logic [15:0]              pload;
		logic [15:0]              cr_value;
		logic [15:0]              boot;
		logic [POSITION_BITS-1:0] position;
		logic [47:0]              hdr;
		logic [SEEN_BITS-1:0]     hdr_seen;
		logic [7:0]               vcount;
	} parse_state_t;

	typedef struct packed {
		logic                   parse_ok;
		logic [15:0]            start_address;
		logic [15:0]            boot_address;
		logic [15:0]            load_address;
		logic [15:0]            words_in_block;
		logic                   wide_word_variant;
		logic [OFFSET_BITS-1:0] payload_offset;
		logic [PBYTES_BITS-1:0] payload_bytes;
	} summary_t;

endpackage

// ----- rtl/bthp_tape_if.sv -----
// Input channel of the tape header parser: one tape byte per request.
// Depends on nothing.
interface bthp_tape_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       last_byte;

	modport source (output valid, output file_byte, output last_byte, input ready);
	modport sink (input valid, input file_byte, input last_byte, output ready);
endinterface

// ----- rtl/bthp_summary_if.sv -----
// Output channel of the tape header parser: one summary per file.
// Depends on bthp_pkg.
interface bthp_summary_if;
	import bthp_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   parse_ok;
	logic [15:0]            start_address;
	logic [15:0]            boot_address;
	logic [15:0]            load_address;
	logic [15:0]            words_in_block;
	logic                   wide_word_variant;
	logic [OFFSET_BITS-1:0] payload_offset;
	logic [PBYTES_BITS-1:0] payload_bytes;

	modport source (output valid, output parse_ok, output start_address, output boot_address,
		output load_address, output words_in_block, output wide_word_variant,
		output payload_offset, output payload_bytes, input ready);
	modport sink (input valid, input parse_ok, input start_address, input boot_address,
		input load_address, input words_in_block, input wide_word_variant,
		input payload_offset, input payload_bytes, output ready);
endinterface

// ----- rtl/bthp_parse.sv -----
// Parse state register and its per-byte update: preamble octal scan and header capture.
// Depends on bthp_pkg.
module bthp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            file_byte,
	input  logic                  last_byte,
	output bthp_pkg::parse_state_t cur,
	output bthp_pkg::parse_state_t nxt
);
	import bthp_pkg::*;

	parse_state_t state_q;
	logic [6:0]   ch;
	logic [15:0]  pl;
	logic         has_num;

	assign cur = state_q;
	assign ch = file_byte[6:0];
	assign has_num = (state_q.digit_count != '0);

	always_comb begin
		nxt = state_q;
		pl = state_q.pload;
		if (state_q.phase == PHASE_PREAMBLE) begin
			if (state_q.position != POS_MAX) begin
				nxt.position = state_q.position + POSITION_BITS'(1);
			end
			if (ch == CHAR_BANG) begin
				if (has_num) begin
					pl = state_q.acc;
				end
				nxt.pload = pl;
				nxt.boot = (pl == state_q.start) ? state_q.cr_value : pl;
				nxt.acc = '0;
				nxt.digit_count = '0;
				nxt.stopped = 1'b0;
				nxt.phase = PHASE_HEADER;
			end else if (ch == CHAR_SLASH) begin
				if (has_num) begin
					nxt.cr_value = state_q.acc;
					nxt.start = state_q.acc;
					if (state_q.pload == '0) begin
						nxt.pload = state_q.acc;
					end
				end
				nxt.acc = '0;
				nxt.digit_count = '0;
				nxt.stopped = 1'b0;
			end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
				if (state_q.digit_count < DIGIT_LIMIT) begin
					nxt.digit_count = state_q.digit_count + DIGIT_BITS'(1);
					if (!state_q.stopped) begin
						if (ch >= CHAR_EIGHT) begin
							nxt.stopped = 1'b1;
						end else begin
							nxt.acc = {state_q.acc[12:0], ch[2:0]};
						end
					end
				end
			end else if (ch == CHAR_CR) begin
				if (has_num) begin
					nxt.cr_value = state_q.acc;
				end
				nxt.acc = '0;
				nxt.digit_count = '0;
				nxt.stopped = 1'b0;
			end
		end else begin
			for (int i = 0; i < HEADER_SLOTS; i++) begin
				if (state_q.hdr_seen == SEEN_BITS'(i)) begin
					nxt.hdr[(HEADER_SLOTS-1-i)*8 +: 8] = file_byte;
				end
			end
			if (state_q.hdr_seen == SEEN_CHECKSUM) begin
				nxt.vcount = file_byte;
			end
			if (state_q.hdr_seen != SEEN_VCOUNT) begin
				nxt.hdr_seen = state_q.hdr_seen + SEEN_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				state_q <= '0;
			end else begin
				state_q <= nxt;
			end
		end
	end
endmodule

// ----- rtl/bthp_summary.sv -----
// Summary of a finished file: length checks, header decode and word variant detection.
// Depends on bthp_pkg.
module bthp_summary (
	input  bthp_pkg::parse_state_t st,
	output bthp_pkg::summary_t     res
);
	import bthp_pkg::*;

	logic [POSITION_BITS:0] total;
	logic                   big_enough;
	logic [15:0]            addr;
	logic [15:0]            cnt;

	assign total = {1'b0, st.position} + (POSITION_BITS+1)'(st.hdr_seen);
	assign big_enough = (st.position >= POSITION_BITS'(MIN_FILE_BYTES)) ||
		(total >= (POSITION_BITS+1)'(MIN_FILE_BYTES));
	assign addr = st.hdr[47:32];
	assign cnt = st.hdr[31:16];

	always_comb begin
		res = '0;
		if (st.phase == PHASE_HEADER && st.hdr_seen >= SEEN_ADDR_CNT && big_enough) begin
			res.parse_ok = 1'b1;
			res.start_address = st.start;
			res.boot_address = st.boot;
			res.load_address = addr;
			res.words_in_block = cnt;
			if (addr == '0 && cnt == '0) begin
				if (st.hdr_seen >= SEEN_CHECKSUM && st.hdr[15:0] == '0) begin
					res.wide_word_variant = 1'b1;
					if (st.hdr_seen == SEEN_VCOUNT) begin
						res.words_in_block = {8'h00, st.vcount};
						res.load_address = st.start;
						res.payload_offset = OFFSET_BITS'(st.position + POSITION_BITS'(7));
						res.payload_bytes = {7'b0, st.vcount, 2'b00};
					end
				end
			end else begin
				res.payload_offset = OFFSET_BITS'(st.position + POSITION_BITS'(4));
				res.payload_bytes = {cnt, 1'b0};
			end
		end
	end
endmodule

// ----- rtl/bootstrap_tape_header_parser.sv -----
// Bootstrap tape header parser, top level.
// Depends on bthp_pkg, bthp_tape_if, bthp_summary_if, bthp_parse and bthp_summary.
//
// Usage: the tape channel carries one byte of a tape image per request, with
// last_byte set on the final byte of a file. The summary channel carries one
// result per file, produced for the request that had last_byte set; no other
// request produces a result.
// Flow: an accepted byte is held in the input stage and updates the parse state
// when it leaves that stage; a final byte's summary is registered at that point.
// Throughput: one byte per cycle while no final byte waits behind an untaken summary.
// Stall: a pending summary does not stop the tape channel; only a final byte
// waiting behind an untaken summary holds the input stage, and then ready drops.
// Reset: arst_n clears the input and output valid flags and all parse
// state; the first byte after reset, and after each final byte, starts a new file.
module bootstrap_tape_header_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	bthp_tape_if.sink             tape,
	bthp_summary_if.source        summary
);
	import bthp_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         adv_s1;
	logic         out_valid_q;
	summary_t     res_q;
	summary_t     res;
	parse_state_t cur;
	parse_state_t nxt;

	assign adv_s1 = valid_s1 && (!last_s1 || !out_valid_q || summary.ready);
	assign tape.ready = !valid_s1 || adv_s1;

	bthp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.file_byte (byte_s1),
		.last_byte (last_s1),
		.cur       (cur),
		.nxt       (nxt)
	);

	bthp_summary u_summary (
		.st  (nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tape.ready) begin
			valid_s1 <= tape.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tape.valid && tape.ready) begin
			byte_s1 <= tape.file_byte;
			last_s1 <= tape.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && summary.ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv_s1 && last_s1) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign summary.valid = out_valid_q;
	assign summary.parse_ok = res_q.parse_ok;
	assign summary.start_address = res_q.start_address;
	assign summary.boot_address = res_q.boot_address;
	assign summary.load_address = res_q.load_address;
	assign summary.words_in_block = res_q.words_in_block;
	assign summary.wide_word_variant = res_q.wide_word_variant;
	assign summary.payload_offset = res_q.payload_offset;
	assign summary.payload_bytes = res_q.payload_bytes;

	a_hold_final: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid_q && !summary.ready) |-> !tape.ready)
		else $error("final byte advanced over an untaken summary");

	a_new_file: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (cur.phase == PHASE_PREAMBLE && cur.position == '0 &&
		cur.hdr_seen == '0))
		else $error("parse state not cleared after a final byte");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(summary.valid && !summary.parse_ok) |-> (summary.payload_offset == '0 &&
		summary.payload_bytes == '0 && summary.wide_word_variant == 1'b0 &&
		summary.boot_address == '0))
		else $error("failed summary carries nonzero fields");

	a_wide_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(summary.valid && summary.wide_word_variant) |-> (summary.payload_bytes[1:0] == 2'b00))
		else $error("word variant byte count not a multiple of four");
endmodule

// ----- bench/bootstrap_tape_header_parser_tb.sv -----
// Self-checking bench for bootstrap_tape_header_parser: drives tape images byte by byte,
// predicts each per-file summary in a scoreboard class and checks the summary channel.
// Depends on bthp_pkg, bthp_tape_if, bthp_summary_if and the parser RTL.
`timescale 1ns / 100ps

module bootstrap_tape_header_parser_tb;
	import bthp_pkg::*;

	class tape_summary_scoreboard;
		parse_state_t st;
		summary_t     expected_q[$];
		int unsigned  bytes_taken;
		int unsigned  files;
		int unsigned  wide_files;
		int unsigned  rejected_files;
		int unsigned  mismatches;

		function new();
			clear_file();
		endfunction

		function void clear_file();
			st = '0;
			st.phase = PHASE_PREAMBLE;
		endfunction

		function void clear_number();
			st.acc = '0;
			st.digit_count = '0;
			st.stopped = 1'b0;
		endfunction

		function void take_byte(logic [7:0] raw, logic fin);
			logic [6:0]               c;
			logic [POSITION_BITS:0]   reach;
			summary_t                 s;
			c = raw[6:0];
			bytes_taken++;
			if (st.phase == PHASE_PREAMBLE) begin
				if (st.position != POS_MAX)
					st.position = st.position + POSITION_BITS'(1);
				if (c == CHAR_BANG) begin
					if (st.digit_count != '0)
						st.pload = st.acc;
					st.boot = (st.pload == st.start) ? st.cr_value : st.pload;
					clear_number();
					st.phase = PHASE_HEADER;
				end else if (c == CHAR_SLASH) begin
					if (st.digit_count != '0) begin
						st.cr_value = st.acc;
						st.start = st.acc;
						if (st.pload == 16'h0000)
							st.pload = st.acc;
					end
					clear_number();
				end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
					if (st.digit_count < DIGIT_LIMIT) begin
						st.digit_count = st.digit_count + DIGIT_BITS'(1);
						if (!st.stopped) begin
							if (c >= CHAR_EIGHT)
								st.stopped = 1'b1;
							else
								st.acc = {st.acc[12:0], c[2:0]};
						end
					end
				end else if (c == CHAR_CR) begin
					if (st.digit_count != '0)
						st.cr_value = st.acc;
					clear_number();
				end
			end else begin
				if (st.hdr_seen < SEEN_CHECKSUM)
					st.hdr = st.hdr | (48'(raw) << (8 * (HEADER_SLOTS - 1 - int'(st.hdr_seen))));
				else if (st.hdr_seen == SEEN_CHECKSUM)
					st.vcount = raw;
				if (st.hdr_seen < SEEN_VCOUNT)
					st.hdr_seen = st.hdr_seen + SEEN_BITS'(1);
			end

			if (fin) begin
				s = '0;
				reach = (POSITION_BITS+1)'(st.position) + (POSITION_BITS+1)'(st.hdr_seen);
				if (st.phase == PHASE_HEADER && st.hdr_seen >= SEEN_ADDR_CNT &&
						reach >= (POSITION_BITS+1)'(MIN_FILE_BYTES)) begin
					s.parse_ok = 1'b1;
					s.start_address = st.start;
					s.boot_address = st.boot;
					s.load_address = st.hdr[47:32];
					s.words_in_block = st.hdr[31:16];
					if (st.hdr[47:16] == 32'h0) begin
						if (st.hdr_seen >= SEEN_CHECKSUM && st.hdr[15:0] == 16'h0000) begin
							s.wide_word_variant = 1'b1;
							if (st.hdr_seen >= SEEN_VCOUNT) begin
								s.words_in_block = {8'h00, st.vcount};
								s.load_address = st.start;
								s.payload_offset = OFFSET_BITS'(st.position +
									POSITION_BITS'(SEEN_VCOUNT));
								s.payload_bytes = PBYTES_BITS'({st.vcount, 2'b00});
							end
						end
					end else begin
						s.payload_offset = OFFSET_BITS'(st.position + POSITION_BITS'(SEEN_ADDR_CNT));
						s.payload_bytes = PBYTES_BITS'({s.words_in_block, 1'b0});
					end
				end
				files++;
				if (s.wide_word_variant)
					wide_files++;
				if (!s.parse_ok)
					rejected_files++;
				expected_q.push_back(s);
				clear_file();
			end
		endfunction

		function void flag_field(string field, longint unsigned want, longint unsigned seen);
			mismatches++;
			if (mismatches <= 10)
				$display("summary mismatch on %s: expected %0h, got %0h", field, want, seen);
		endfunction

		function void compare_summary(summary_t got);
			summary_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("summary with nothing pending: %h", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.parse_ok !== want.parse_ok)
				flag_field("parse_ok", want.parse_ok, got.parse_ok);
			if (got.start_address !== want.start_address)
				flag_field("start_address", want.start_address, got.start_address);
			if (got.boot_address !== want.boot_address)
				flag_field("boot_address", want.boot_address, got.boot_address);
			if (got.load_address !== want.load_address)
				flag_field("load_address", want.load_address, got.load_address);
			if (got.words_in_block !== want.words_in_block)
				flag_field("words_in_block", want.words_in_block, got.words_in_block);
			if (got.wide_word_variant !== want.wide_word_variant)
				flag_field("wide_word_variant", want.wide_word_variant, got.wide_word_variant);
			if (got.payload_offset !== want.payload_offset)
				flag_field("payload_offset", want.payload_offset, got.payload_offset);
			if (got.payload_bytes !== want.payload_bytes)
				flag_field("payload_bytes", want.payload_bytes, got.payload_bytes);
		endfunction

		function void report_leftover();
			summary_t want;
			while (expected_q.size() != 0) begin
				want = expected_q.pop_front();
				mismatches++;
				if (mismatches <= 10)
					$display("summary never arrived: expected %h", want);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   quiet;
	int   hold_left;
	logic [7:0] tape_file[$];
	tape_summary_scoreboard sb;

	bthp_tape_if    tape();
	bthp_summary_if summary();

	bootstrap_tape_header_parser uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tape    (tape),
		.summary (summary)
	);

	always #5 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin : summary_sink
		summary_t got;
		int hold;
		if (arst_n) begin
			if (summary.valid && summary.ready) begin
				got.parse_ok = summary.parse_ok;
				got.start_address = summary.start_address;
				got.boot_address = summary.boot_address;
				got.load_address = summary.load_address;
				got.words_in_block = summary.words_in_block;
				got.wide_word_variant = summary.wide_word_variant;
				got.payload_offset = summary.payload_offset;
				got.payload_bytes = summary.payload_bytes;
				sb.compare_summary(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				summary.ready <= 1'b0;
			end else begin
				hold = idle_len();
				if (hold > 0) begin
					hold_left = hold - 1;
					summary.ready <= 1'b0;
				end else begin
					summary.ready <= 1'b1;
				end
			end
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			tape.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tape.valid <= 1'b1;
		tape.file_byte <= b;
		tape.last_byte <= fin;
		@(posedge clk);
		while (!tape.ready) @(posedge clk);
		sb.take_byte(b, fin);
	endtask

	task automatic send_file();
		for (int i = 0; i < tape_file.size(); i++)
			push_byte(tape_file[i], i == tape_file.size() - 1);
	endtask

	function automatic logic [7:0] tape_char(input logic [6:0] c);
		return {$urandom_range(0, 3) == 0, c};
	endfunction

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 11))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic void add_number();
		int r;
		int len;
		r = $urandom_range(0, 99);
		if (r < 85)
			len = $urandom_range(1, 6);
		else if (r < 95)
			len = $urandom_range(7, 20);
		else
			len = $urandom_range(45, 60);
		repeat (len) begin
			if ($urandom_range(0, 14) == 0)
				tape_file.push_back(tape_char(CHAR_EIGHT + 7'($urandom_range(0, 1))));
			else
				tape_file.push_back(tape_char(CHAR_ZERO + 7'($urandom_range(0, 7))));
		end
	endfunction

	function automatic void add_filler();
		logic [6:0] c;
		do
			c = 7'($urandom_range(0, 127));
		while (c == CHAR_BANG || c == CHAR_SLASH || c == CHAR_CR ||
			(c >= CHAR_ZERO && c <= CHAR_NINE));
		tape_file.push_back(tape_char(c));
	endfunction

	function automatic void build_file();
		int kind;
		int extra;
		int keep;
		extra = 0;
		tape_file.delete();
		if ($urandom_range(0, 99) < 12) begin
			repeat ($urandom_range(1, 24)) tape_file.push_back(8'($urandom));
			return;
		end
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					add_number();
					tape_file.push_back(tape_char(CHAR_SLASH));
				end
				2: begin
					add_number();
					tape_file.push_back(tape_char(CHAR_CR));
				end
				3: add_number();
				4: tape_file.push_back(tape_char($urandom_range(0, 1) ? CHAR_SLASH : CHAR_CR));
				default: add_filler();
			endcase
		end
		if ($urandom_range(0, 1))
			add_number();
		tape_file.push_back(tape_char(CHAR_BANG));
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			repeat (4) tape_file.push_back(rand_byte());
			extra = $urandom_range(0, 8);
		end else if (kind < 55) begin
			repeat (4) tape_file.push_back(8'h00);
			repeat (2) tape_file.push_back($urandom_range(0, 1) ? 8'h00 : rand_byte());
			extra = $urandom_range(0, 5);
		end else if (kind < 80) begin
			repeat (6) tape_file.push_back(8'h00);
			tape_file.push_back(rand_byte());
			extra = $urandom_range(0, 8);
		end else if (kind < 90) begin
			repeat ($urandom_range(4, 6)) tape_file.push_back(8'h00);
		end else begin
			repeat ($urandom_range(0, 3)) tape_file.push_back(rand_byte());
		end
		repeat (extra) tape_file.push_back(rand_byte());
		if ($urandom_range(0, 19) == 0) begin
			keep = $urandom_range(1, tape_file.size());
			while (tape_file.size() > keep) void'(tape_file.pop_back());
		end
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_left = 0;
		tape.valid = 1'b0;
		tape.file_byte = 8'h00;
		tape.last_byte = 1'b0;
		summary.ready = 1'b0;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// short file, masked preamble with word-variant header, variant without count byte
		tape_file = '{8'h37, 8'h2F, 8'h21, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_file();
		tape_file = '{8'hB7, 8'hAF, 8'h35, 8'h0D, 8'hA1,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09};
		send_file();
		tape_file = '{8'h31, 8'h39, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_file();

		while (sb.bytes_taken < 1850) begin
			quiet = ($urandom_range(0, 7) == 0);
			build_file();
			send_file();
		end
		tape.valid <= 1'b0;

		// drain with the sink ready once any hold under way has run out
		quiet = 1'b1;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		sb.report_leftover();

		$display("ran %0d tape bytes in %0d files: %0d word-variant headers, %0d rejected",
			sb.bytes_taken, sb.files, sb.wide_files, sb.rejected_files);
		$display("summary field mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0)
			$display("bootstrap_tape_header_parser_tb OK");
		else
			$display("bootstrap_tape_header_parser_tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout waiting for the parser");
		$display("bootstrap_tape_header_parser_tb NOT OK");
		$finish;
	end

endmodule
